>>> rtl/stp_pkg.sv
package stp_pkg;

  localparam int MAX_VARS  = 8;
  localparam int MAX_CONS  = 8;
  localparam int FRAC_BITS = 16;

  localparam int NROWS   = MAX_CONS + 1;
  localparam int NCOLS   = MAX_VARS + MAX_CONS + 2;
  localparam int RHS_COL = NCOLS - 1;
  localparam int LCOLS   = MAX_VARS + 1;

  localparam int ROW_W = $clog2(NROWS);
  localparam int COL_W = $clog2(NCOLS);
  localparam int WA_W  = $clog2(NROWS * NCOLS);
  localparam int LA_W  = $clog2(NROWS * LCOLS);

  localparam int DIV_W   = 32 + FRAC_BITS;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [1:0] FUNC_OBJ   = 2'd0;
  localparam logic [1:0] FUNC_CON   = 2'd1;
  localparam logic [1:0] FUNC_RHS   = 2'd2;
  localparam logic [1:0] FUNC_SOLVE = 2'd3;

  localparam logic [1:0] CFG_NUM_VARS = 2'd0;
  localparam logic [1:0] CFG_NUM_CONS = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER = 2'd2;

  localparam logic [1:0] ST_OPTIMAL   = 2'd0;
  localparam logic [1:0] ST_UNBOUNDED = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_REJECTED  = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/stp_div.sv
module stp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  stp_pkg::div_req_t req,
  output stp_pkg::div_rsp_t rsp
);
  import stp_pkg::*;

  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W-1:0]  dq_r;
  logic [31:0]       rem_r;
  logic [31:0]       dsr_r;
  logic [32:0]       trial;
  logic              qbit;

  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign qbit  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dq_r   <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= qbit ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
        dq_r  <= {dq_r[DIV_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

>>> rtl/stp_mul.sv
module stp_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);
  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

>>> rtl/simplex_tableau_solver.sv
// Tableau simplex maximiser, Q16.16. Load words (objective, constraint, rhs) give no
// result. A solve word first copies the loaded problem into the working tableau, then
// each pivot runs the entering-column scan, the ratio test over each constraint row,
// the pivot row (18 entries) through the bit-serial divider, and every other row
// through the shared multiplier. All tableau traffic goes through one working memory
// with separate read and write ports. One result word per row 0..num_cons follows, each
// held until taken. in_ready is low from the solve word until the last result is taken.
module simplex_tableau_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [2:0]         in_row,
  input  logic [2:0]         in_col,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_row_index,
  output logic [4:0]         out_basic_var,
  output logic signed [31:0] out_row_value,
  output logic [1:0]         out_status,
  output logic [7:0]         out_iterations,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import stp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT_RD, S_INIT_WR, S_ENT_RD, S_ENT_CHK, S_ENT_END,
    S_RAT_E_RD, S_RAT_E_CHK, S_RAT_R_RD, S_RAT_R_GET, S_RAT_M1, S_RAT_M2, S_RAT_CMP,
    S_RAT_NEXT, S_RAT_END, S_PR_RD, S_PR_START, S_PR_WAIT,
    S_EL_F_RD, S_EL_F_GET, S_EL_P_RD, S_EL_W_RD, S_EL_MUL, S_EL_WR, S_EL_NEXT,
    S_PIV_END, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  localparam logic signed [31:0] Q_ONE = 32'(64'd1 << FRAC_BITS);

  state_t state_r;

  logic [3:0] cfg_nv_r, cfg_nc_r;
  logic [7:0] cfg_max_r;

  logic [COL_W-1:0] nv_r;
  logic [ROW_W-1:0] nc_r;
  logic [7:0]       max_r;
  logic [7:0]       pcount_r;
  logic             rej_r;

  logic [ROW_W-1:0] i_r, lr_r;
  logic [COL_W-1:0] j_r, ec_r;
  logic             found_r;
  logic signed [31:0] best_r, best_e_r, best_r_r, e_r, r_r, f_r, p_r, wv_r;
  logic signed [63:0] t_r;
  logic             neg_r;
  logic [4:0]       labels_r [NROWS];

  logic [31:0]      lmem [NROWS * LCOLS];
  logic             lvalid_r [NROWS * LCOLS];
  logic [31:0]      lrd_r;
  logic             lval_r;

  logic signed [31:0] wmem [NROWS * NCOLS];
  logic signed [31:0] rdata_r;

  logic               out_valid_r, out_last_r;
  logic [3:0]         out_row_r;
  logic [4:0]         out_basic_r;
  logic signed [31:0] out_value_r;
  logic [1:0]         out_status_r;

  logic               accept;
  logic               ld_we;
  logic [LA_W-1:0]    ld_addr, lrd_addr;
  logic [31:0]        ld_data;
  logic [WA_W-1:0]    w_raddr, w_waddr;
  logic               w_we;
  logic signed [31:0] w_wdata;
  logic signed [31:0] init_val, pr_val, el_val;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic [31:0]        mag32;
  logic [63:0]        pmag, prnd;
  logic signed [63:0] rs;
  logic signed [64:0] diff;
  logic [COL_W-1:0]   lk;

  function automatic logic [WA_W-1:0] waddr(input logic [ROW_W-1:0] r,
                                            input logic [COL_W-1:0] c);
    return WA_W'(int'(r) * NCOLS + int'(c));
  endfunction

  function automatic logic [1:0] end_status(input logic rej, input logic [1:0] code);
    return rej ? ST_REJECTED : code;
  endfunction

  stp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  stp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // load decode
  always_comb begin
    ld_we   = 1'b0;
    ld_addr = '0;
    ld_data = in_value;
    unique case (in_func)
      FUNC_OBJ: begin
        ld_we   = accept && (int'(in_col) < MAX_VARS) && (in_value > 0);
        ld_addr = LA_W'(int'(in_col));
        ld_data = 32'(-in_value);
      end
      FUNC_CON: begin
        ld_we   = accept && (int'(in_row) < MAX_CONS) && (int'(in_col) < MAX_VARS);
        ld_addr = LA_W'((int'(in_row) + 1) * LCOLS + int'(in_col));
      end
      FUNC_RHS: begin
        ld_we   = accept && (int'(in_row) < MAX_CONS) && (in_value >= 0);
        ld_addr = LA_W'((int'(in_row) + 1) * LCOLS + MAX_VARS);
      end
      default: ld_we = 1'b0;
    endcase
  end

  assign lk       = (j_r > COL_W'(MAX_VARS)) ? COL_W'(MAX_VARS) :
                    (j_r == '0) ? '0 : j_r - 1'b1;
  assign lrd_addr = LA_W'(int'(i_r) * LCOLS + int'(lk));

  always_ff @(posedge clk) begin
    if (ld_we) lmem[ld_addr] <= ld_data;
    lrd_r <= lmem[lrd_addr];
    lval_r <= lvalid_r[lrd_addr];
  end

  always_comb begin
    init_val = '0;
    if (i_r == '0 && j_r == '0) init_val = Q_ONE;
    if (i_r <= nc_r && j_r >= COL_W'(1) && j_r <= nv_r) init_val = lval_r ? lrd_r : '0;
    if (i_r != '0 && i_r <= nc_r && int'(j_r) == MAX_VARS + int'(i_r)) init_val = Q_ONE;
    if (i_r != '0 && i_r <= nc_r && j_r == COL_W'(RHS_COL))
      init_val = lval_r ? lrd_r : '0;
  end

  always_comb begin
    unique case (state_r)
      S_ENT_RD:   w_raddr = waddr('0, j_r);
      S_RAT_E_RD: w_raddr = waddr(i_r, ec_r);
      S_RAT_R_RD: w_raddr = waddr(i_r, COL_W'(RHS_COL));
      S_PR_RD:    w_raddr = waddr(lr_r, j_r);
      S_EL_F_RD:  w_raddr = waddr(i_r, ec_r);
      S_EL_P_RD:  w_raddr = waddr(lr_r, j_r);
      S_EL_W_RD:  w_raddr = waddr(i_r, j_r);
      S_OUT_RD:   w_raddr = waddr(i_r, COL_W'(RHS_COL));
      default:    w_raddr = '0;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_RAT_M1: begin mul_a = r_r;      mul_b = best_e_r; end
      S_RAT_M2: begin mul_a = best_r_r; mul_b = e_r;      end
      S_EL_MUL: begin mul_a = f_r;      mul_b = p_r;      end
      default:  begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  // pivot row: round(a * 2^F / p)
  assign mag32         = rdata_r[31] ? 32'(-rdata_r) : 32'(rdata_r);
  assign dreq.start    = state_r == S_PR_START;
  assign dreq.dividend = DIV_W'({mag32, {FRAC_BITS{1'b0}}}) + DIV_W'(best_e_r >>> 1);
  assign dreq.divisor  = best_e_r;

  always_comb begin
    if (neg_r) begin
      pr_val = (drsp.quotient > DIV_W'(33'h080000000)) ? 32'sh80000000 :
               32'(-drsp.quotient);
    end else begin
      pr_val = (drsp.quotient > DIV_W'(32'h7fffffff)) ? 32'sh7fffffff :
               32'(drsp.quotient);
    end
  end

  // other rows: w - round(f * p / 2^F)
  assign pmag = prod[63] ? 64'(-prod) : 64'(prod);
  assign prnd = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rs   = prod[63] ? -$signed(prnd) : $signed(prnd);
  assign diff = 65'(wv_r) - 65'(rs);

  always_comb begin
    if (diff > 65'sh07fffffff)       el_val = 32'sh7fffffff;
    else if (diff < -65'sh080000000) el_val = 32'sh80000000;
    else                             el_val = 32'(diff);
  end

  always_comb begin
    w_we    = 1'b0;
    w_waddr = waddr(i_r, j_r);
    w_wdata = init_val;
    unique case (state_r)
      S_INIT_WR: w_we = 1'b1;
      S_PR_WAIT: begin
        w_we    = drsp.done;
        w_waddr = waddr(lr_r, j_r);
        w_wdata = pr_val;
      end
      S_EL_WR: begin
        w_we    = 1'b1;
        w_wdata = el_val;
      end
      default: w_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    rdata_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nv_r  <= 4'd2;
      cfg_nc_r  <= 4'd2;
      cfg_max_r <= 8'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_VARS: cfg_nv_r  <= cfg_data[3:0];
        CFG_NUM_CONS: cfg_nc_r  <= cfg_data[3:0];
        CFG_MAX_ITER: cfg_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rej_r       <= 1'b0;
      pcount_r    <= '0;
      max_r       <= 8'd32;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NROWS * LCOLS; k++) lvalid_r[k] <= 1'b0;
      labels_r[0] <= '0;
      for (int k = 1; k < NROWS; k++) labels_r[k] <= 5'(MAX_VARS + k);
    end else begin
      if (ld_we) lvalid_r[ld_addr] <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_func == FUNC_SOLVE) begin
              nv_r <= (cfg_nv_r == '0) ? COL_W'(1) :
                      (int'(cfg_nv_r) > MAX_VARS) ? COL_W'(MAX_VARS) : COL_W'(cfg_nv_r);
              nc_r <= (cfg_nc_r == '0) ? ROW_W'(1) :
                      (int'(cfg_nc_r) > MAX_CONS) ? ROW_W'(MAX_CONS) : ROW_W'(cfg_nc_r);
              max_r    <= cfg_max_r;
              pcount_r <= '0;
              labels_r[0] <= '0;
              for (int k = 1; k < NROWS; k++) labels_r[k] <= 5'(MAX_VARS + k);
              i_r     <= '0;
              j_r     <= '0;
              state_r <= S_INIT_RD;
            end else if (!ld_we) begin
              rej_r <= 1'b1;
            end
          end
        end
        S_INIT_RD: state_r <= S_INIT_WR;
        S_INIT_WR: begin
          if (j_r == COL_W'(RHS_COL)) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
            if (i_r == ROW_W'(NROWS - 1)) begin
              j_r     <= COL_W'(1);
              best_r  <= '0;
              found_r <= 1'b0;
              state_r <= S_ENT_RD;
            end else begin
              state_r <= S_INIT_RD;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_INIT_RD;
          end
        end
        S_ENT_RD: state_r <= S_ENT_CHK;
        S_ENT_CHK: begin
          if (rdata_r < best_r) begin
            best_r  <= rdata_r;
            ec_r    <= j_r;
            found_r <= 1'b1;
          end
          if (j_r == COL_W'(RHS_COL - 1)) begin
            state_r <= S_ENT_END;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_ENT_RD;
          end
        end
        S_ENT_END: begin
          if (!found_r) begin
            out_status_r <= end_status(rej_r, ST_OPTIMAL);
            rej_r        <= 1'b0;
            i_r          <= '0;
            state_r      <= S_OUT_RD;
          end else begin
            i_r     <= ROW_W'(1);
            found_r <= 1'b0;
            state_r <= S_RAT_E_RD;
          end
        end
        S_RAT_E_RD: state_r <= S_RAT_E_CHK;
        S_RAT_E_CHK: begin
          e_r     <= rdata_r;
          state_r <= (rdata_r <= 0) ? S_RAT_NEXT : S_RAT_R_RD;
        end
        S_RAT_R_RD: state_r <= S_RAT_R_GET;
        S_RAT_R_GET: begin
          r_r <= rdata_r;
          if (!found_r) begin
            found_r  <= 1'b1;
            lr_r     <= i_r;
            best_e_r <= e_r;
            best_r_r <= rdata_r;
            state_r  <= S_RAT_NEXT;
          end else begin
            state_r <= S_RAT_M1;
          end
        end
        S_RAT_M1: state_r <= S_RAT_M2;
        S_RAT_M2: begin
          t_r     <= prod;
          state_r <= S_RAT_CMP;
        end
        S_RAT_CMP: begin
          if (t_r < prod) begin
            lr_r     <= i_r;
            best_e_r <= e_r;
            best_r_r <= r_r;
          end
          state_r <= S_RAT_NEXT;
        end
        S_RAT_NEXT: begin
          if (i_r == nc_r) begin
            state_r <= S_RAT_END;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RAT_E_RD;
          end
        end
        S_RAT_END: begin
          if (!found_r || pcount_r >= max_r) begin
            out_status_r <= end_status(rej_r, found_r ? ST_LIMIT : ST_UNBOUNDED);
            rej_r        <= 1'b0;
            i_r          <= '0;
            state_r      <= S_OUT_RD;
          end else begin
            j_r     <= '0;
            state_r <= S_PR_RD;
          end
        end
        S_PR_RD: state_r <= S_PR_START;
        S_PR_START: begin
          neg_r   <= rdata_r[31];
          state_r <= S_PR_WAIT;
        end
        S_PR_WAIT: begin
          if (drsp.done) begin
            if (j_r == COL_W'(RHS_COL)) begin
              i_r     <= '0;
              state_r <= S_EL_F_RD;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_PR_RD;
            end
          end
        end
        S_EL_F_RD: state_r <= (i_r == lr_r) ? S_EL_NEXT : S_EL_F_GET;
        S_EL_F_GET: begin
          f_r     <= rdata_r;
          j_r     <= '0;
          state_r <= S_EL_P_RD;
        end
        S_EL_P_RD: state_r <= S_EL_W_RD;
        S_EL_W_RD: begin
          p_r     <= rdata_r;
          state_r <= S_EL_MUL;
        end
        S_EL_MUL: begin
          wv_r    <= rdata_r;
          state_r <= S_EL_WR;
        end
        S_EL_WR: begin
          if (j_r == COL_W'(RHS_COL)) begin
            state_r <= S_EL_NEXT;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_EL_P_RD;
          end
        end
        S_EL_NEXT: begin
          if (i_r == nc_r) begin
            state_r <= S_PIV_END;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_EL_F_RD;
          end
        end
        S_PIV_END: begin
          labels_r[lr_r] <= 5'(ec_r);
          pcount_r       <= pcount_r + 1'b1;
          j_r            <= COL_W'(1);
          best_r         <= '0;
          found_r        <= 1'b0;
          state_r        <= S_ENT_RD;
        end
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: begin
          out_valid_r <= 1'b1;
          out_row_r   <= 4'(i_r);
          out_basic_r <= labels_r[i_r];
          out_value_r <= rdata_r;
          out_last_r  <= i_r == nc_r;
          state_r     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_row_r;
  assign out_basic_var  = out_basic_r;
  assign out_row_value  = out_value_r;
  assign out_status     = out_status_r;
  assign out_iterations = pcount_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  a_out_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT_WAIT)
    else $error("result word outside output phase");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_PR_WAIT)
    else $error("divider finished outside pivot row phase");

  a_pivot_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> pcount_r <= max_r)
    else $error("pivot count beyond limit");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_row_r == 4'(nc_r))
    else $error("last word not on final row");
`endif

endmodule

>>> dv/testbench.sv
import stp_pkg::*;

typedef struct packed {
  logic [3:0]  row_index;
  logic [4:0]  basic_var;
  logic [31:0] row_value;
  logic [1:0]  status;
  logic [7:0]  iterations;
  logic        last;
} row_word_t;

class lp_scoreboard;
  int        tab[NROWS][NCOLS];
  bit        rejected;
  int        vars_reg, cons_reg, iter_lim;
  row_word_t pending[$];
  int        errors, shown;

  function new();
    foreach (tab[i, j]) tab[i][j] = 0;
    rejected = 0;
    vars_reg = 2;
    cons_reg = 2;
    iter_lim = 32;
    errors = 0;
    shown = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] d);
    if (idx == CFG_NUM_VARS) vars_reg = int'(d[3:0]);
    else if (idx == CFG_NUM_CONS) cons_reg = int'(d[3:0]);
    else if (idx == CFG_MAX_ITER) iter_lim = int'(d);
  endfunction

  function int sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return int'(x);
  endfunction

  function int qdiv(int a, int p);
    longint num, m, q;
    num = longint'(a) * (64'sd1 <<< FRAC_BITS);
    m = num < 0 ? -num : num;
    q = (m + p / 2) / p;
    return sat32(num < 0 ? -q : q);
  endfunction

  function longint qmul(int a, int b);
    longint prod, m, r;
    prod = longint'(a) * longint'(b);
    m = prod < 0 ? -prod : prod;
    r = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return prod < 0 ? -r : r;
  endfunction

  // predicts the row words of a solve word; loads only update the stored problem or mark it rejected
  function void take_word(logic [1:0] func, logic [2:0] row, logic [2:0] col, int value);
    int        w[NROWS][NCOLS];
    int        lab[NROWS];
    int        nv, nc, iters, st, ec, lr, best, p, f;
    row_word_t r;
    if (func == FUNC_OBJ) begin
      if (value > 0) tab[0][1 + col] = -value;
      else rejected = 1;
      return;
    end
    if (func == FUNC_CON) begin
      tab[1 + row][1 + col] = value;
      return;
    end
    if (func == FUNC_RHS) begin
      if (value >= 0) tab[1 + row][RHS_COL] = value;
      else rejected = 1;
      return;
    end
    nv = vars_reg < 1 ? 1 : (vars_reg > MAX_VARS ? MAX_VARS : vars_reg);
    nc = cons_reg < 1 ? 1 : (cons_reg > MAX_CONS ? MAX_CONS : cons_reg);
    foreach (w[i, j]) w[i][j] = 0;
    w[0][0] = 1 << FRAC_BITS;
    for (int i = 0; i <= nc; i++) begin
      for (int j = 1; j <= nv; j++) w[i][j] = tab[i][j];
      if (i > 0) begin
        w[i][MAX_VARS + i] = 1 << FRAC_BITS;
        w[i][RHS_COL] = tab[i][RHS_COL];
      end
    end
    lab[0] = 0;
    for (int i = 1; i < NROWS; i++) lab[i] = MAX_VARS + i;
    iters = 0;
    forever begin
      ec = -1;
      lr = -1;
      best = 0;
      for (int j = 1; j < RHS_COL; j++)
        if (w[0][j] < best) begin
          best = w[0][j];
          ec = j;
        end
      if (ec < 0) begin
        st = ST_OPTIMAL;
        break;
      end
      for (int i = 1; i <= nc; i++) begin
        if (w[i][ec] <= 0) continue;
        if (lr < 0 || longint'(w[i][RHS_COL]) * w[lr][ec] <
            longint'(w[lr][RHS_COL]) * w[i][ec]) lr = i;
      end
      if (lr < 0) begin
        st = ST_UNBOUNDED;
        break;
      end
      if (iters >= iter_lim) begin
        st = ST_LIMIT;
        break;
      end
      p = w[lr][ec];
      for (int j = 0; j < NCOLS; j++) w[lr][j] = qdiv(w[lr][j], p);
      for (int i = 0; i <= nc; i++) begin
        if (i == lr) continue;
        f = w[i][ec];
        for (int j = 0; j < NCOLS; j++) w[i][j] = sat32(longint'(w[i][j]) - qmul(f, w[lr][j]));
      end
      lab[lr] = ec;
      iters++;
    end
    if (rejected) st = ST_REJECTED;
    rejected = 0;
    for (int i = 0; i <= nc; i++) begin
      r.row_index = 4'(i);
      r.basic_var = 5'(lab[i]);
      r.row_value = w[i][RHS_COL];
      r.status = 2'(st);
      r.iterations = 8'(iters);
      r.last = (i == nc);
      pending = {pending, r};
    end
  endfunction

  function void check(row_word_t got);
    row_word_t exp_w;
    if (pending.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result word %p", got);
      end
      return;
    end
    exp_w = pending.pop_front();
    if (got !== exp_w) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: expected %p got %p", exp_w, got);
      end
    end
  endfunction
endclass

module testbench;
  localparam int LIMIT = 80000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_OBJ;
  logic [2:0]         in_row = 0;
  logic [2:0]         in_col = 0;
  logic signed [31:0] in_value = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [3:0]         out_row_index;
  logic [4:0]         out_basic_var;
  logic signed [31:0] out_row_value;
  logic [1:0]         out_status;
  logic [7:0]         out_iterations;
  logic               out_last;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_NUM_VARS;
  logic [7:0]         cfg_data = 0;

  lp_scoreboard sb = new();
  bit           quiet = 0;
  int           sent = 0;

  simplex_tableau_solver dut (.*);

  always #4 clk = ~clk;

  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= 36);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check({out_row_index, out_basic_var, out_row_value, out_status, out_iterations,
                out_last});

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(logic [1:0] func, logic [2:0] row, logic [2:0] col, int value);
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_func = func;
    in_row = row;
    in_col = col;
    in_value = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_word(func, row, col, value);
    sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic settle();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] d);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_all(int nv, int nc, int it);
    settle();
    write_reg(CFG_NUM_VARS, 8'(nv));
    write_reg(CFG_NUM_CONS, 8'(nc));
    write_reg(CFG_MAX_ITER, 8'(it));
  endtask

  function automatic int coeff();
    int k;
    k = $urandom_range(9);
    if (k == 0) return $urandom;
    if (k < 3) return ($urandom_range(8) - 3) <<< 16;
    return (($urandom_range(7) - 2) <<< 16) + $urandom_range(65535);
  endfunction

  function automatic int pos_val();
    if ($urandom_range(9) == 0) return $urandom_range(32'h7fffffff, 1);
    return ($urandom_range(9) <<< 16) + $urandom_range(65535) + 1;
  endfunction

  initial begin
    int nv, nc;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    // directed: empty problem, then a small textbook problem
    send_word(FUNC_SOLVE, 0, 0, 0);
    send_word(FUNC_OBJ, 0, 0, 3 << 16);
    send_word(FUNC_OBJ, 0, 1, 5 << 16);
    send_word(FUNC_CON, 0, 0, 1 << 16);
    send_word(FUNC_RHS, 0, 0, 4 << 16);
    send_word(FUNC_CON, 1, 0, 3 << 16);
    send_word(FUNC_CON, 1, 1, 2 << 16);
    send_word(FUNC_RHS, 1, 0, 18 << 16);
    send_word(FUNC_SOLVE, 7, 7, -1);
    // rejected loads
    send_word(FUNC_OBJ, 0, 2, 0);
    send_word(FUNC_SOLVE, 0, 0, 0);
    send_word(FUNC_OBJ, 0, 3, 32'h80000000);
    send_word(FUNC_RHS, 2, 0, -1);
    send_word(FUNC_SOLVE, 0, 0, 0);
    // unbounded second variable
    send_word(FUNC_CON, 1, 1, -(1 << 16));
    send_word(FUNC_SOLVE, 0, 0, 0);
    // extremes outside the registers
    send_word(FUNC_OBJ, 0, 7, 32'h7fffffff);
    send_word(FUNC_CON, 7, 7, 32'h80000000);
    send_word(FUNC_CON, 6, 7, 32'h7fffffff);
    send_word(FUNC_RHS, 7, 0, 32'h7fffffff);
    set_all(8, 8, 255);
    send_word(FUNC_SOLVE, 0, 0, 0);
    set_all(0, 0, 0);
    send_word(FUNC_SOLVE, 0, 0, 0);
    set_all(15, 15, 1);
    send_word(FUNC_SOLVE, 0, 0, 0);

    for (int ph = 0; sent < 115; ph++) begin
      quiet = (ph == 1 || ph == 2);
      if ($urandom_range(4) == 0) begin
        nv = $urandom_range(15);
        nc = $urandom_range(15);
      end else begin
        nv = $urandom_range(3, 1);
        nc = $urandom_range(3, 1);
      end
      set_all(nv, nc, $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(12, 1));
      nv = nv < 1 ? 1 : (nv > 8 ? 8 : nv);
      nc = nc < 1 ? 1 : (nc > 8 ? 8 : nc);
      if (nv * nc > 16) begin
        nv = $urandom_range(3, 1);
        nc = nc > 3 ? nc : nc;
      end
      repeat (2) begin
        for (int j = 0; j < nv; j++) send_word(FUNC_OBJ, 3'($urandom), 3'(j), pos_val());
        for (int i = 0; i < nc; i++) begin
          for (int j = 0; j < nv; j++) send_word(FUNC_CON, 3'(i), 3'(j), coeff());
          send_word(FUNC_RHS, 3'(i), 3'($urandom), pos_val() - 1);
        end
        // noise and broken loads
        repeat ($urandom_range(2))
          send_word(2'($urandom_range(2)), 3'($urandom), 3'($urandom),
                    $urandom_range(3) == 0 ? -1 : $urandom);
        send_word(FUNC_SOLVE, 3'($urandom), 3'($urandom), $urandom);
      end
    end
    quiet = 0;
    settle();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
